// ===== rtl/first_fit_block_allocator_assert.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
// Checks a condition at every clock edge outside reset.
`define FFBA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Checks that an antecedent implies a consequent in the following cycle.
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/ffba_pkg.sv =====
// Constants and codes shared by the first-fit allocator modules.
`default_nettype none
package ffba_pkg;
  localparam int REGION_BYTES        = 65536;
  localparam int TABLE_SLOTS         = 2048;
  localparam int GRANULE_BYTES       = 8;
  localparam int REGION_HEADER_BYTES = 32;
  localparam int BLOCK_HEADER_BYTES  = 16;
  localparam int USER_LIMIT = REGION_BYTES - REGION_HEADER_BYTES - BLOCK_HEADER_BYTES;
  localparam int HDR_SLOTS = REGION_BYTES / GRANULE_BYTES;
  localparam int GRAN_SH   = $clog2(GRANULE_BYTES);
  localparam int HDR_AW    = $clog2(HDR_SLOTS);
  localparam int TBL_AW    = $clog2(TABLE_SLOTS);
  localparam int CNT_W     = TBL_AW + 1;
  localparam int SIZE_W    = 17;
  localparam int HDR_W     = SIZE_W + 1;
  localparam int OFF_W     = 16;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_NO_FIT   = 2'd2;
  localparam logic [1:0] ST_BAD_FREE = 2'd3;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // One header entry: used flag and user size.
  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
  } hdr_t;
endpackage
`default_nettype wire

// ===== rtl/ffba_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module ffba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data, updated only when re_i is set.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator: sequencer around header and table RAMs.
// Usage: one request channel (kind_i, request_bytes_i, block_offset_i) with
// in_valid_i / in_stall_o, and one result channel (result_offset_o, status_o,
// remaining_bytes_o) with out_valid_o / out_stall_i. Every request gives one result.
// A request is taken only when the sequencer is idle; one request is worked at a time.
// An allocate walks the header chain, reading and then evaluating each header visited.
// On a fit it marks the header used, writes a new free header behind it when the block
// is split, and then records the block in the table. A free scans the allocation table,
// reading and comparing each entry; on a match it moves the last entry into the hole
// and frees the block's header. A rejected request goes from its check to the result.
// The result sits in an output register; the next request may be taken while it
// waits. If the receiver stalls and a new result is ready, the sequencer holds
// in its final state until the register empties.
// Reset empties the table and leaves one free block spanning the region; the
// first header is supplied by a reset-valid flag, so no clearing pass is needed.
`default_nettype none
`include "first_fit_block_allocator_assert.svh"
module first_fit_block_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [15:0] request_bytes_i,
  input  wire logic [15:0] block_offset_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      result_offset_o,
  output logic [1:0]       status_o,
  output logic [16:0]      remaining_bytes_o
);
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] S_A_CHK  = 4'd1;
  localparam logic [ST_W-1:0] S_A_RD   = 4'd2;
  localparam logic [ST_W-1:0] S_A_EVAL = 4'd3;
  localparam logic [ST_W-1:0] S_A_SPL  = 4'd4;
  localparam logic [ST_W-1:0] S_A_TBL  = 4'd5;
  localparam logic [ST_W-1:0] S_F_CHK  = 4'd6;
  localparam logic [ST_W-1:0] S_F_RD   = 4'd7;
  localparam logic [ST_W-1:0] S_F_EVAL = 4'd8;
  localparam logic [ST_W-1:0] S_F_LAST = 4'd9;
  localparam logic [ST_W-1:0] S_F_HDR  = 4'd10;
  localparam logic [ST_W-1:0] S_FIN    = 4'd11;

  localparam logic [ffba_pkg::HDR_AW-1:0] FIRST_SLOT =
    ffba_pkg::HDR_AW'(ffba_pkg::REGION_HEADER_BYTES / ffba_pkg::GRANULE_BYTES);
  localparam logic [ffba_pkg::SIZE_W-1:0] LIMIT = ffba_pkg::SIZE_W'(ffba_pkg::USER_LIMIT);
  localparam logic [ffba_pkg::SIZE_W-1:0] BHDR = ffba_pkg::SIZE_W'(ffba_pkg::BLOCK_HEADER_BYTES);
  localparam logic [ffba_pkg::SIZE_W-1:0] SPLIT_MIN =
    ffba_pkg::SIZE_W'(ffba_pkg::BLOCK_HEADER_BYTES + ffba_pkg::GRANULE_BYTES);
  localparam logic [ffba_pkg::SIZE_W-1:0] GMASK = ffba_pkg::SIZE_W'(ffba_pkg::GRANULE_BYTES - 1);
  localparam logic [17:0] WALK_END = 18'(ffba_pkg::REGION_BYTES -
    ffba_pkg::BLOCK_HEADER_BYTES - ffba_pkg::GRANULE_BYTES);
  localparam logic [15:0] FREE_MIN = 16'(ffba_pkg::REGION_HEADER_BYTES +
    ffba_pkg::BLOCK_HEADER_BYTES);
  localparam logic [ffba_pkg::CNT_W-1:0] FULL = ffba_pkg::CNT_W'(ffba_pkg::TABLE_SLOTS);

  logic [ST_W-1:0] state_q, state_d;
  logic kind_q;
  logic [15:0] req_q, off_q, pos_q, pos_d;
  logic [ffba_pkg::SIZE_W-1:0] cnt_q, cnt_d, rem_q, rem_d;
  logic [ffba_pkg::CNT_W-1:0] acnt_q, acnt_d, idx_q, idx_d;
  logic [ffba_pkg::SIZE_W-1:0] nsize_q, nsize_d;
  logic [ffba_pkg::HDR_AW-1:0] nslot_q, nslot_d;
  logic [1:0] res_st_q, res_st_d;
  logic [15:0] res_off_q, res_off_d;
  logic first_fresh_q, fresh_rd_q;
  logic ov_q;
  logic [15:0] o_off_q;
  logic [1:0] o_st_q;
  logic [16:0] o_rem_q;

  logic hdr_we, hdr_re, tbl_we, tbl_re;
  logic [ffba_pkg::HDR_AW-1:0] hdr_waddr, hdr_raddr;
  ffba_pkg::hdr_t hdr_wdata, hdr_rdata, hdr_ram_q;
  logic [ffba_pkg::TBL_AW-1:0] tbl_waddr, tbl_raddr;
  logic [15:0] tbl_wdata, tbl_rdata;
  logic accept, fin_go;
  logic [ffba_pkg::SIZE_W-1:0] round_cnt, eff_size;
  logic [17:0] nxt;
  logic [16:0] np;
  logic [15:0] user;

  ffba_ram #(.WIDTH(ffba_pkg::HDR_W), .DEPTH(ffba_pkg::HDR_SLOTS)) u_hdr (
    .clk_i(clk_i), .we_i(hdr_we), .waddr_i(hdr_waddr), .wdata_i(hdr_wdata),
    .re_i(hdr_re), .raddr_i(hdr_raddr), .rdata_o(hdr_ram_q)
  );

  ffba_ram #(.WIDTH(16), .DEPTH(ffba_pkg::TABLE_SLOTS)) u_tbl (
    .clk_i(clk_i), .we_i(tbl_we), .waddr_i(tbl_waddr), .wdata_i(tbl_wdata),
    .re_i(tbl_re), .raddr_i(tbl_raddr), .rdata_o(tbl_rdata)
  );

  // The first header reads as the spanning free block until it is first written.
  always_comb begin
    hdr_rdata = hdr_ram_q;
    if (fresh_rd_q) begin
      hdr_rdata.used = 1'b0;
      hdr_rdata.size = LIMIT;
    end
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign fin_go     = !ov_q || !out_stall_i;
  assign round_cnt  = ({1'b0, req_q} + GMASK) & ~GMASK;
  assign user       = pos_q + 16'(ffba_pkg::BLOCK_HEADER_BYTES);
  assign nxt        = {2'b00, pos_q} + 18'(BHDR) + {1'b0, hdr_rdata.size};
  assign np         = {1'b0, user} + cnt_q;
  assign eff_size   = (hdr_rdata.size >= cnt_q + SPLIT_MIN) ? cnt_q + BHDR : hdr_rdata.size;

  // Sequencer: walks headers for allocates, scans the table for frees.
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    acnt_d    = acnt_q;
    idx_d     = idx_q;
    nsize_d   = nsize_q;
    nslot_d   = nslot_q;
    res_st_d  = res_st_q;
    res_off_d = res_off_q;
    hdr_we    = 1'b0;
    hdr_re    = 1'b0;
    hdr_waddr = pos_q[15:ffba_pkg::GRAN_SH];
    hdr_raddr = pos_q[15:ffba_pkg::GRAN_SH];
    hdr_wdata = '0;
    tbl_we    = 1'b0;
    tbl_re    = 1'b0;
    tbl_waddr = acnt_q[ffba_pkg::TBL_AW-1:0];
    tbl_raddr = idx_q[ffba_pkg::TBL_AW-1:0];
    tbl_wdata = user;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (kind_i == ffba_pkg::KIND_FREE) ? S_F_CHK : S_A_CHK;
        end
      end
      S_A_CHK: begin
        res_off_d = '0;
        cnt_d     = round_cnt;
        pos_d     = 16'(ffba_pkg::REGION_HEADER_BYTES);
        if (req_q == '0 || {1'b0, req_q} >= LIMIT) begin
          res_st_d = ffba_pkg::ST_BAD_SIZE;
          state_d  = S_FIN;
        end else if (round_cnt > rem_q || acnt_q >= FULL) begin
          res_st_d = ffba_pkg::ST_NO_FIT;
          state_d  = S_FIN;
        end else begin
          state_d = S_A_RD;
        end
      end
      S_A_RD: begin
        hdr_re  = 1'b1;
        state_d = S_A_EVAL;
      end
      S_A_EVAL: begin
        if (!hdr_rdata.used && hdr_rdata.size >= cnt_q) begin
          hdr_we         = 1'b1;
          hdr_wdata.used = 1'b1;
          rem_d = (eff_size > rem_q) ? '0 : rem_q - eff_size;
          if (hdr_rdata.size >= cnt_q + SPLIT_MIN) begin
            hdr_wdata.size = cnt_q;
            nslot_d = np[15:ffba_pkg::GRAN_SH];
            nsize_d = hdr_rdata.size - cnt_q - BHDR;
            state_d = S_A_SPL;
          end else begin
            hdr_wdata.size = hdr_rdata.size;
            state_d = S_A_TBL;
          end
        end else if (nxt > WALK_END) begin
          res_st_d = ffba_pkg::ST_NO_FIT;
          state_d  = S_FIN;
        end else begin
          pos_d   = nxt[15:0];
          state_d = S_A_RD;
        end
      end
      S_A_SPL: begin
        hdr_we         = 1'b1;
        hdr_waddr      = nslot_q;
        hdr_wdata.used = 1'b0;
        hdr_wdata.size = nsize_q;
        state_d        = S_A_TBL;
      end
      S_A_TBL: begin
        tbl_we    = 1'b1;
        acnt_d    = acnt_q + 1'b1;
        res_off_d = user;
        res_st_d  = ffba_pkg::ST_OK;
        state_d   = S_FIN;
      end
      S_F_CHK: begin
        res_off_d = '0;
        idx_d     = '0;
        if (off_q < FREE_MIN || acnt_q == '0) begin
          res_st_d = ffba_pkg::ST_BAD_FREE;
          state_d  = S_FIN;
        end else begin
          state_d = S_F_RD;
        end
      end
      S_F_RD: begin
        tbl_re  = 1'b1;
        state_d = S_F_EVAL;
      end
      S_F_EVAL: begin
        if (tbl_rdata == off_q) begin
          tbl_re    = 1'b1;
          tbl_raddr = ffba_pkg::TBL_AW'(acnt_q - 1'b1);
          state_d   = S_F_LAST;
        end else if (idx_q + 1'b1 == acnt_q) begin
          res_st_d = ffba_pkg::ST_BAD_FREE;
          state_d  = S_FIN;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_F_RD;
        end
      end
      S_F_LAST: begin
        tbl_we    = 1'b1;
        tbl_waddr = idx_q[ffba_pkg::TBL_AW-1:0];
        tbl_wdata = tbl_rdata;
        acnt_d    = acnt_q - 1'b1;
        hdr_re    = 1'b1;
        hdr_raddr = ffba_pkg::HDR_AW'(16'(off_q - 16'(ffba_pkg::BLOCK_HEADER_BYTES))
                    >> ffba_pkg::GRAN_SH);
        state_d   = S_F_HDR;
      end
      S_F_HDR: begin
        hdr_we         = 1'b1;
        hdr_waddr      = ffba_pkg::HDR_AW'(16'(off_q - 16'(ffba_pkg::BLOCK_HEADER_BYTES))
                         >> ffba_pkg::GRAN_SH);
        hdr_wdata.used = 1'b0;
        hdr_wdata.size = hdr_rdata.size;
        rem_d          = rem_q + hdr_rdata.size;
        res_st_d       = ffba_pkg::ST_OK;
        state_d        = S_FIN;
      end
      S_FIN: begin
        if (fin_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      acnt_q        <= '0;
      rem_q         <= LIMIT;
      first_fresh_q <= 1'b1;
      fresh_rd_q    <= 1'b0;
      ov_q          <= 1'b0;
    end else begin
      state_q <= state_d;
      acnt_q  <= acnt_d;
      rem_q   <= rem_d;
      if (hdr_re) begin
        fresh_rd_q <= first_fresh_q && (hdr_raddr == FIRST_SLOT);
      end
      if (hdr_we && hdr_waddr == FIRST_SLOT) begin
        first_fresh_q <= 1'b0;
      end
      if (state_q == S_FIN && fin_go) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Request and working payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      req_q  <= request_bytes_i;
      off_q  <= block_offset_i;
    end
    pos_q     <= pos_d;
    cnt_q     <= cnt_d;
    idx_q     <= idx_d;
    nsize_q   <= nsize_d;
    nslot_q   <= nslot_d;
    res_st_q  <= res_st_d;
    res_off_q <= res_off_d;
    if (state_q == S_FIN && fin_go) begin
      o_off_q <= (kind_q == ffba_pkg::KIND_FREE) ? '0 : res_off_q;
      o_st_q  <= res_st_q;
      o_rem_q <= rem_q;
    end
  end

  assign out_valid_o       = ov_q;
  assign result_offset_o   = o_off_q;
  assign status_o          = o_st_q;
  assign remaining_bytes_o = o_rem_q;

  `FFBA_ASSERT(a_count_bound, acnt_q <= FULL, "allocation count above table size")
  `FFBA_ASSERT(a_rem_bound, rem_q <= LIMIT, "remaining bytes above user area")
  `FFBA_ASSERT(a_no_hdr_overlap, !(hdr_we && hdr_re && hdr_waddr == hdr_raddr), "header clash")
  `FFBA_ASSERT_NEXT(a_fin_result, state_q == S_FIN && fin_go, ov_q, "finished request gave no result")
endmodule
`default_nettype wire

// ===== test/first_fit_block_allocator_checker.sv =====
// Checker that predicts and compares the allocator's results.
`timescale 1ns / 100ps
module first_fit_block_allocator_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        kind_i,
  input  logic [15:0] request_bytes_i,
  input  logic [15:0] block_offset_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] result_offset_i,
  input  logic [1:0]  status_i,
  input  logic [16:0] remaining_bytes_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] offset;
    logic [1:0]  status;
    logic [16:0] remaining;
  } alloc_result_t;

  // Shadow copy of the region: header sizes and used flags per granule slot.
  int unsigned   shadow_size [ffba_pkg::HDR_SLOTS];
  bit            shadow_used [ffba_pkg::HDR_SLOTS];
  int unsigned   live_table [ffba_pkg::TABLE_SLOTS];
  int unsigned   live_count;
  int unsigned   free_bytes;
  alloc_result_t expected_results [$];

  function automatic int unsigned slot_at(int unsigned pos);
    return (pos / ffba_pkg::GRANULE_BYTES) % ffba_pkg::HDR_SLOTS;
  endfunction

  function automatic alloc_result_t pack_result(int unsigned off, logic [1:0] st);
    alloc_result_t r;
    r.offset    = off[15:0];
    r.status    = st;
    r.remaining = free_bytes[16:0];
    return r;
  endfunction

  // First-fit walk from the first header; splits when the remainder can hold a header
  // and one granule.
  function automatic alloc_result_t predict_allocate(int unsigned count);
    int unsigned pos;
    int unsigned s;
    int unsigned sz;
    int unsigned nxt;
    int unsigned np;
    int unsigned user;
    pos = ffba_pkg::REGION_HEADER_BYTES;
    if (count == 0 || count >= ffba_pkg::USER_LIMIT)
      return pack_result(0, ffba_pkg::ST_BAD_SIZE);
    if (count % ffba_pkg::GRANULE_BYTES != 0)
      count += ffba_pkg::GRANULE_BYTES - (count % ffba_pkg::GRANULE_BYTES);
    if (count > free_bytes || live_count >= ffba_pkg::TABLE_SLOTS)
      return pack_result(0, ffba_pkg::ST_NO_FIT);
    for (int steps = 0; steps < ffba_pkg::HDR_SLOTS; steps++) begin
      s  = slot_at(pos);
      sz = shadow_size[s];
      if (!shadow_used[s] && sz >= count) begin
        user = pos + ffba_pkg::BLOCK_HEADER_BYTES;
        shadow_used[s] = 1'b1;
        if (sz >= count + ffba_pkg::BLOCK_HEADER_BYTES + ffba_pkg::GRANULE_BYTES) begin
          np = user + count;
          shadow_size[s] = count;
          shadow_size[slot_at(np)] = sz - count - ffba_pkg::BLOCK_HEADER_BYTES;
          shadow_used[slot_at(np)] = 1'b0;
          sz = count + ffba_pkg::BLOCK_HEADER_BYTES;
        end
        free_bytes = (sz > free_bytes) ? 0 : free_bytes - sz;
        live_table[live_count % ffba_pkg::TABLE_SLOTS] = user;
        live_count++;
        return pack_result(user, ffba_pkg::ST_OK);
      end
      nxt = pos + ffba_pkg::BLOCK_HEADER_BYTES + sz;
      if (nxt >= ffba_pkg::REGION_BYTES || ffba_pkg::REGION_BYTES - nxt <
          ffba_pkg::BLOCK_HEADER_BYTES + ffba_pkg::GRANULE_BYTES)
        break;
      pos = nxt;
    end
    return pack_result(0, ffba_pkg::ST_NO_FIT);
  endfunction

  // Table lookup; the last entry fills the hole of the released one.
  function automatic alloc_result_t predict_release(int unsigned off);
    int unsigned s;
    if (off >= ffba_pkg::REGION_HEADER_BYTES + ffba_pkg::BLOCK_HEADER_BYTES &&
        off < ffba_pkg::REGION_BYTES) begin
      for (int unsigned i = 0; i < live_count && i < ffba_pkg::TABLE_SLOTS; i++) begin
        if (live_table[i] == off) begin
          s = slot_at(off - ffba_pkg::BLOCK_HEADER_BYTES);
          live_count--;
          live_table[i] = live_table[live_count % ffba_pkg::TABLE_SLOTS];
          shadow_used[s] = 1'b0;
          free_bytes += shadow_size[s];
          return pack_result(0, ffba_pkg::ST_OK);
        end
      end
    end
    return pack_result(0, ffba_pkg::ST_BAD_FREE);
  endfunction

  initial begin
    fail_count_o = 0;
    live_count   = 0;
    free_bytes   = ffba_pkg::USER_LIMIT;
    foreach (shadow_size[i]) begin
      shadow_size[i] = 0;
      shadow_used[i] = 1'b0;
    end
    shadow_size[slot_at(ffba_pkg::REGION_HEADER_BYTES)] = ffba_pkg::USER_LIMIT;
  end

  assign pending_o = expected_results.size();

  // Predict on each accepted request, then compare each accepted result.
  always @(posedge clk_i) begin
    alloc_result_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        if (kind_i == ffba_pkg::KIND_ALLOC)
          expected_results.push_back(predict_allocate(request_bytes_i));
        else expected_results.push_back(predict_release(block_offset_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("Result arrived with no request outstanding");
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result_offset_i !== exp_r.offset) begin
            $error("result_offset: expected %0d, got %0d", exp_r.offset, result_offset_i);
            fail_count_o++;
          end
          if (status_i !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_i);
            fail_count_o++;
          end
          if (remaining_bytes_i !== exp_r.remaining) begin
            $error("remaining_bytes: expected %0d, got %0d", exp_r.remaining,
                   remaining_bytes_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

// ===== test/first_fit_block_allocator_tb.sv =====
// Testbench top for the first-fit block allocator: stimulus, idling and verdict.
`timescale 1ns / 100ps
module first_fit_block_allocator_tb;

  localparam int RANDOM_REQUESTS = 1030;
  localparam int QUIET_FROM      = 900;
  localparam int WATCHDOG_LIMIT  = 100000;
  localparam int HOLD_CYCLES     = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = ffba_pkg::KIND_ALLOC;
  logic [15:0] request_bytes_i = '0;
  logic [15:0] block_offset_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] result_offset_o;
  logic [1:0]  status_o;
  logic [16:0] remaining_bytes_o;
  int          fail_count;
  int          pending;
  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;
  int          idle_cycles = 0;
  int unsigned live_offsets [$];

  always #5 clk_i = ~clk_i;

  first_fit_block_allocator dut (.*);

  first_fit_block_allocator_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .request_bytes_i,
    .block_offset_i, .out_valid_i(out_valid_o), .out_stall_i, .result_offset_i(result_offset_o),
    .status_i(status_o), .remaining_bytes_i(remaining_bytes_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Collect granted offsets so that later free requests hit live blocks.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i && status_o == ffba_pkg::ST_OK && result_offset_o != 0)
      live_offsets.push_back(result_offset_o);
  end

  // Watchdog: count cycles in which neither channel moves.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clk_i);
        hold_request = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offers one request from a falling edge and holds it until taken; valid stays
  // high into the next falling edge, where the next request or an idle gap follows.
  task automatic send_request(logic kind, logic [15:0] bytes, logic [15:0] offset);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    request_bytes_i <= bytes;
    block_offset_i  <= offset;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 16'($urandom_range(1, 64));
    if (roll < 85) return 16'($urandom_range(65, 1024));
    if (roll < 95) return 16'($urandom_range(1025, 8192));
    if (roll < 97) return 16'd0;
    return 16'($urandom);
  endfunction

  initial begin
    int unsigned idx;
    logic [15:0] off;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: bad sizes, whole-region grant, empty region, bad frees, splits, near fit.
    send_request(ffba_pkg::KIND_ALLOC, 16'd0, 16'hFFFF);
    send_request(ffba_pkg::KIND_ALLOC, 16'hFFFF, 16'd0);
    send_request(ffba_pkg::KIND_ALLOC, 16'(ffba_pkg::USER_LIMIT), 16'd0);
    send_request(ffba_pkg::KIND_ALLOC, 16'(ffba_pkg::USER_LIMIT - 1), 16'd0);
    send_request(ffba_pkg::KIND_ALLOC, 16'd8, 16'd0);
    send_request(ffba_pkg::KIND_FREE, 16'hFFFF, 16'd48);
    send_request(ffba_pkg::KIND_FREE, 16'd0, 16'd48);
    send_request(ffba_pkg::KIND_FREE, 16'd0, 16'd0);
    send_request(ffba_pkg::KIND_FREE, 16'd0, 16'hFFFF);
    send_request(ffba_pkg::KIND_FREE, 16'd0, 16'd47);
    send_request(ffba_pkg::KIND_FREE, 16'd0, 16'd100);
    send_request(ffba_pkg::KIND_ALLOC, 16'd16, 16'd0);
    send_request(ffba_pkg::KIND_ALLOC, 16'd8, 16'd0);
    send_request(ffba_pkg::KIND_FREE, 16'd0, 16'd48);
    send_request(ffba_pkg::KIND_ALLOC, 16'd8, 16'd0);
    send_request(ffba_pkg::KIND_ALLOC, 16'd1, 16'd0);
    send_request(ffba_pkg::KIND_ALLOC, 16'd9, 16'd0);
    send_request(ffba_pkg::KIND_ALLOC, 16'd40000, 16'd0);
    send_request(ffba_pkg::KIND_ALLOC, 16'd30000, 16'd0);
    send_request(ffba_pkg::KIND_FREE, 16'd0, 16'd96);
    in_valid_i <= 1'b0;
    wait (pending == 0);

    // Random: mostly allocates and frees of live blocks, some malformed requests.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == QUIET_FROM) quiet = 1'b1;
      if (n == 400) hold_request = 1'b1;
      if (live_offsets.size() > 0 &&
          $urandom_range(0, 99) < ((live_offsets.size() > 120) ? 70 : 40)) begin
        idx = $urandom_range(0, live_offsets.size() - 1);
        off = 16'(live_offsets[idx]);
        live_offsets.delete(idx);
        send_request(ffba_pkg::KIND_FREE, 16'($urandom), off);
      end else if ($urandom_range(0, 99) < 8) begin
        send_request(ffba_pkg::KIND_FREE, 16'($urandom), 16'($urandom));
      end else begin
        send_request(ffba_pkg::KIND_ALLOC, pick_size(), 16'($urandom));
      end
    end
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
